// File: sv/sbrp_pkg.sv
// Shared types and constants of the STUN binding response parser.
// No dependencies; every other file imports this package.
package sbrp_pkg;

  // Status codes of one result item
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_WRONG_TYPE = 3'd1;
  localparam logic [2:0] ST_NO_MAPPED = 3'd2;
  localparam logic [2:0] ST_BAD_FAMILY = 3'd3;
  localparam logic [2:0] ST_TRUNCATED = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_RESPONSE_TYPE = 2'd0;
  localparam logic [1:0] CFG_MAPPED_TYPE   = 2'd1;
  localparam logic [1:0] CFG_ID_LENGTH     = 2'd2;

  // Address families
  localparam logic [15:0] FAMILY_IPV4 = 16'd1;
  localparam logic [15:0] FAMILY_IPV6 = 16'd2;

  // Longest transaction id that is skipped
  localparam logic [4:0] ID_LENGTH_MAX = 5'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] response_type;
    logic [15:0] mapped_type;
    logic [4:0]  id_length;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        is_ipv6;
    logic [15:0] mapped_port;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } result_t;

endpackage

// File: sv/sbrp_in_reg.sv
// Input register of the STUN binding response parser.
// Depends on sbrp_pkg for the input item type.
module sbrp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sbrp_pkg::in_item_t in_item,
  input  logic              out_free,
  output logic              take,
  output sbrp_pkg::in_item_t item
);
  import sbrp_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     adv;

  // A held item moves on unless it closes a datagram and the result slot is full
  assign adv      = valid_r && (!item_r.last_byte || out_free);
  assign in_ready = !valid_r || adv;
  assign take     = adv;
  assign item     = item_r;

  // Hold the item until the parser takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// File: sv/sbrp_parser.sv
// Byte-wise parse state of the STUN binding response parser and the
// result it forms on the final byte. Depends on sbrp_pkg.
module sbrp_parser #(
  parameter int MAX_DATAGRAM_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               take,
  input  sbrp_pkg::in_item_t item,
  input  sbrp_pkg::cfg_t     cfg,
  output logic               res_valid,
  output sbrp_pkg::result_t  res
);
  import sbrp_pkg::*;

  localparam int POS_W = $clog2(MAX_DATAGRAM_BYTES + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_DATAGRAM_BYTES);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_ID       = 3'd1;
  localparam logic [2:0] PH_ATTR_HDR = 3'd2;
  localparam logic [2:0] PH_VALUE    = 3'd3;
  localparam logic [2:0] PH_MAPPED   = 3'd4;
  localparam logic [2:0] PH_SKIP     = 3'd5;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic [15:0]      hdr_r, hdr_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [4:0]       vi_r, vi_nxt;
  logic             found_r, found_nxt;
  logic [15:0]      fam_r, fam_nxt;
  logic [15:0]      port_r, port_nxt;
  logic [63:0]      a0_r, a0_nxt;
  logic [63:0]      a1_r, a1_nxt;
  logic [2:0]       err_r, err_nxt;

  logic [4:0] idlen;
  logic [4:0] vi_inc;
  logic       close;
  logic [2:0] status;
  logic [7:0] b;

  assign b      = item.data_byte;
  assign idlen  = (cfg.id_length > ID_LENGTH_MAX) ? ID_LENGTH_MAX : cfg.id_length;
  assign vi_inc = vi_r + 5'd1;

  // Advance the parse by one byte, then form the result on the final byte
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    rem_nxt   = rem_r;
    vi_nxt    = vi_r;
    found_nxt = found_r;
    fam_nxt   = fam_r;
    port_nxt  = port_r;
    a0_nxt    = a0_r;
    a1_nxt    = a1_r;
    err_nxt   = err_r;
    close     = 1'b0;
    status    = ST_OK;
    res       = '0;
    res_valid = take && item.last_byte;

    // Bytes past the receive buffer are dropped
    if (take && (pos_r < POS_MAX)) begin
      pos_nxt = pos_r + POS_W'(1);
      unique case (phase_r)
        PH_HEADER: begin
          if (pos_r < POS_W'(2)) begin
            hdr_nxt = {hdr_r[7:0], b};
          end
          if (pos_r == POS_W'(3)) begin
            if (hdr_r != cfg.response_type) begin
              phase_nxt = PH_SKIP;
            end else if (idlen == 5'd0) begin
              phase_nxt = PH_ATTR_HDR;
            end else begin
              phase_nxt = PH_ID;
            end
            vi_nxt = 5'd0;
          end
        end
        PH_ID: begin
          if (vi_inc >= idlen) begin
            phase_nxt = PH_ATTR_HDR;
            vi_nxt    = 5'd0;
          end else begin
            vi_nxt = vi_inc;
          end
        end
        PH_ATTR_HDR: begin
          if (vi_r < 5'd2) begin
            hdr_nxt = {hdr_r[7:0], b};
          end else begin
            rem_nxt = {rem_r[7:0], b};
          end
          vi_nxt = vi_inc;
          if (vi_r == 5'd3) begin
            vi_nxt = 5'd0;
            if (!found_r && (hdr_nxt == cfg.mapped_type)) begin
              found_nxt = 1'b1;
              fam_nxt   = '0;
              port_nxt  = '0;
              a0_nxt    = '0;
              a1_nxt    = '0;
              phase_nxt = PH_MAPPED;
              close     = (rem_nxt == 16'd0);
            end else if (rem_nxt != 16'd0) begin
              phase_nxt = PH_VALUE;
            end
          end
        end
        PH_VALUE: begin
          rem_nxt = rem_r - 16'd1;
          if (rem_nxt == 16'd0) begin
            phase_nxt = PH_ATTR_HDR;
            vi_nxt    = 5'd0;
          end
        end
        PH_MAPPED: begin
          if (vi_r < 5'd20) begin
            if (vi_r < 5'd2) begin
              fam_nxt = {fam_r[7:0], b};
            end else if (vi_r < 5'd4) begin
              port_nxt = {port_r[7:0], b};
            end else if (vi_r < 5'd12) begin
              a0_nxt = {a0_r[55:0], b};
            end else begin
              a1_nxt = {a1_r[55:0], b};
            end
            vi_nxt = vi_inc;
          end
          rem_nxt = rem_r - 16'd1;
          close   = (rem_nxt == 16'd0);
        end
        default: begin
        end
      endcase

      // Close the mapped attribute: check its length against its family
      if (close) begin
        if (vi_nxt < 5'd2) begin
          err_nxt = ST_TRUNCATED;
        end else if (fam_nxt == FAMILY_IPV4) begin
          err_nxt = (vi_nxt >= 5'd8) ? ST_OK : ST_TRUNCATED;
        end else if (fam_nxt == FAMILY_IPV6) begin
          err_nxt = (vi_nxt >= 5'd20) ? ST_OK : ST_TRUNCATED;
        end else begin
          err_nxt = ST_BAD_FAMILY;
        end
        phase_nxt = PH_ATTR_HDR;
        vi_nxt    = 5'd0;
      end
    end

    // Status from the state after this byte
    if (phase_nxt == PH_HEADER) begin
      status = ST_TRUNCATED;
    end else if (phase_nxt == PH_SKIP) begin
      status = ST_WRONG_TYPE;
    end else if ((phase_nxt != PH_ATTR_HDR) || (vi_nxt != 5'd0)) begin
      status = ST_TRUNCATED;
    end else if (!found_nxt) begin
      status = ST_NO_MAPPED;
    end else begin
      status = err_nxt;
    end

    res.status = status;
    if (status == ST_OK) begin
      res.mapped_port = port_nxt;
      if (fam_nxt == FAMILY_IPV6) begin
        res.is_ipv6   = 1'b1;
        res.addr_high = a0_nxt;
        res.addr_low  = a1_nxt;
      end else begin
        res.addr_low = {32'd0, a0_nxt[31:0]};
      end
    end

    // Return to the header phase after the final byte
    if (res_valid) begin
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      vi_nxt    = 5'd0;
      found_nxt = 1'b0;
      err_nxt   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      vi_r    <= 5'd0;
      found_r <= 1'b0;
      err_r   <= ST_OK;
    end else begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      vi_r    <= vi_nxt;
      found_r <= found_nxt;
      err_r   <= err_nxt;
    end
  end

  // Field registers are always written before they are read
  always_ff @(posedge clk) begin
    hdr_r  <= hdr_nxt;
    rem_r  <= rem_nxt;
    fam_r  <= fam_nxt;
    port_r <= port_nxt;
    a0_r   <= a0_nxt;
    a1_r   <= a1_nxt;
  end

endmodule

// File: sv/sbrp_out_reg.sv
// Result register of the STUN binding response parser.
// Depends on sbrp_pkg for the result type.
module sbrp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  sbrp_pkg::result_t res,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_ready,
  output sbrp_pkg::result_t out_res
);
  import sbrp_pkg::*;

  logic    valid_r;
  result_t res_r;

  assign out_free  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  // Hold the item until the consumer takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

// File: sv/stun_binding_response_parser.sv
// Top level of the STUN binding response parser: configuration registers,
// input register, parser and result register. Depends on sbrp_pkg.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   in_data_byte, in_last_byte
//   out      output     out_valid / out_ready status, port, address fields
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One byte per cycle while no final byte waits on a full result register; a final
// byte's result is offered once it has passed the input and result registers.
// Synchronous active-low reset restores the register defaults and the header phase.
// Only a final byte waits for a full result register; while it waits the input stalls.
// Configuration writes are taken in every cycle.
module stun_binding_response_parser #(
  parameter int MAX_DATAGRAM_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_is_ipv6,
  output logic [15:0] out_mapped_port,
  output logic [63:0] out_addr_high,
  output logic [63:0] out_addr_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import sbrp_pkg::*;

  cfg_t     cfg_r;
  in_item_t in_item;
  in_item_t item;
  logic     take;
  logic     out_free;
  logic     res_valid;
  result_t  res;
  result_t  out_res;

  assign cfg_ready = 1'b1;
  assign in_item   = '{data_byte: in_data_byte, last_byte: in_last_byte};

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_type <= 16'h0101;
      cfg_r.mapped_type   <= 16'd1;
      cfg_r.id_length     <= ID_LENGTH_MAX;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RESPONSE_TYPE: cfg_r.response_type <= cfg_data;
        CFG_MAPPED_TYPE:   cfg_r.mapped_type   <= cfg_data;
        CFG_ID_LENGTH:     cfg_r.id_length     <= cfg_data[4:0];
        default: begin
        end
      endcase
    end
  end

  sbrp_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_free (out_free),
    .take     (take),
    .item     (item)
  );

  sbrp_parser #(
    .MAX_DATAGRAM_BYTES (MAX_DATAGRAM_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .item      (item),
    .cfg       (cfg_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sbrp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status      = out_res.status;
  assign out_is_ipv6     = out_res.is_ipv6;
  assign out_mapped_port = out_res.mapped_port;
  assign out_addr_high   = out_res.addr_high;
  assign out_addr_low    = out_res.addr_low;

endmodule
